[hw/rtl/rpcdf_pkg.sv]
// Package: phases, result kinds and error codes of the RPC call-header deframer
package rpcdf_pkg;

    typedef enum logic [3:0] {
        PH_MARK     = 4'd0,
        PH_XID      = 4'd1,
        PH_MTYPE    = 4'd2,
        PH_RPCVERS  = 4'd3,
        PH_PROG     = 4'd4,
        PH_VERS     = 4'd5,
        PH_PROC     = 4'd6,
        PH_CREDFL   = 4'd7,
        PH_CREDLEN  = 4'd8,
        PH_CREDBODY = 4'd9,
        PH_VERFFL   = 4'd10,
        PH_VERFLEN  = 4'd11,
        PH_VERFBODY = 4'd12,
        PH_PAYLOAD  = 4'd13,
        PH_PAYMARK  = 4'd14
    } phase_t;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_CRED    = 3'd1;
    localparam logic [2:0] KIND_VERF    = 3'd2;
    localparam logic [2:0] KIND_HEADER  = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NOT_CALL = 3'd1;
    localparam logic [2:0] ERR_RPC_VERS = 3'd2;
    localparam logic [2:0] ERR_OPAQUE   = 3'd3;
    localparam logic [2:0] ERR_OVERRUN  = 3'd4;

    localparam logic [9:0] MAX_OPAQUE_RESET = 10'd400;
    localparam logic [31:0] RPC_VERSION     = 32'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] xid;
        logic [31:0] prog;
        logic [31:0] vers;
        logic [31:0] proc_num;
        logic [31:0] cred_fl;
        logic [31:0] verf_fl;
        logic [2:0]  err;
    } result_t;

endpackage

[hw/rtl/rpcdf_out_reg.sv]
// Output register stage with a skid entry between parser and result channel
module rpcdf_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rpcdf_pkg::result_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rpcdf_pkg::result_t  out_data
);

    logic               main_valid_reg;
    logic               skid_valid_reg;
    rpcdf_pkg::result_t main_reg;
    rpcdf_pkg::result_t skid_reg;

    assign in_stall  = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || !out_stall)
            begin
                // advance: skid first, then the new word
                if (skid_valid_reg)
                begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_valid_reg <= in_valid;
                end
            end
            else if (in_valid && !skid_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || !out_stall)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        if (in_valid && !skid_valid_reg)
        begin
            skid_reg <= in_data;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed under stall");
    a_skid_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output");
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> !skid_valid_reg)
        else $error("skid entry not drained");

endmodule

[hw/rtl/rpc_call_header_deframer.sv]
// Top level: ONC RPC record-marked call-header parser, one byte per word
//
// Input channel: in_valid / in_stall carry stream_byte and restart. Every
// accepted word yields exactly one result word on out_valid / out_stall with
// result_kind, data_byte, last_payload, the header fields and error_code.
// A word's result is registered in the output stage before it is offered.
// Throughput: one word per cycle while in_stall is low; the parser state
// updates in a single pass between input handshake and output register.
// The output stage holds one result plus one skid entry; while the receiver
// stalls, the held result does not change and the input is stalled once the
// skid entry is full.
// max_opaque_wr / max_opaque_data write the opaque length limit (reset 400);
// write only while idle.
// Reset clears the parser to await a record mark, clears any latched error
// and empties the output stage.
module rpc_call_header_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        max_opaque_wr,
    input  logic [9:0]  max_opaque_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [7:0]  data_byte,
    output logic        last_payload,
    output logic [31:0] call_xid,
    output logic [31:0] program_res,
    output logic [31:0] prog_version,
    output logic [31:0] procedure,
    output logic [31:0] cred_flavor,
    output logic [31:0] verf_flavor,
    output logic [2:0]  error_code
);

    rpcdf_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  biw_reg, biw_next;
    logic [31:0] shift_reg, shift_next;
    logic [30:0] frag_reg, frag_next;
    logic        final_reg, final_next;
    logic [9:0]  opq_reg, opq_next;
    logic [1:0]  pad_reg, pad_next;
    logic [31:0] xid_reg, xid_next;
    logic [31:0] prog_reg, prog_next;
    logic [31:0] vers_reg, vers_next;
    logic [31:0] proc_reg, proc_next;
    logic [31:0] cfl_reg, cfl_next;
    logic [31:0] vfl_reg, vfl_next;
    logic        err_reg, err_next;
    logic [9:0]  max_opq_reg;

    rpcdf_pkg::result_t res;
    rpcdf_pkg::result_t out_res;
    logic        accept;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        rpcdf_pkg::phase_t ph;
        logic [1:0]  biw;
        logic [31:0] sh;
        logic [30:0] fr;
        logic        fin;
        logic        err;
        logic [31:0] w;
        logic        is_data;
        logic        vend;
        ph  = phase_reg;
        biw = biw_reg;
        sh  = shift_reg;
        fr  = frag_reg;
        fin = final_reg;
        err = err_reg;
        w   = '0;
        is_data = 1'b0;
        vend = 1'b0;
        phase_next = phase_reg;
        biw_next   = biw_reg;
        shift_next = shift_reg;
        frag_next  = frag_reg;
        final_next = final_reg;
        opq_next   = opq_reg;
        pad_next   = pad_reg;
        xid_next   = xid_reg;
        prog_next  = prog_reg;
        vers_next  = vers_reg;
        proc_next  = proc_reg;
        cfl_next   = cfl_reg;
        vfl_next   = vfl_reg;
        err_next   = err_reg;
        res = '0;

        if (restart)
        begin
            ph = rpcdf_pkg::PH_MARK;
            biw = '0;
            sh = '0;
            fr = '0;
            fin = 1'b0;
            err = 1'b0;
            phase_next = rpcdf_pkg::PH_MARK;
            biw_next = '0;
            shift_next = '0;
            frag_next = '0;
            final_next = 1'b0;
            opq_next = '0;
            pad_next = '0;
            err_next = 1'b0;
        end

        if (err)
        begin
            res.kind = rpcdf_pkg::KIND_ERROR;
            res.err  = sh[2:0];
        end
        else if (ph == rpcdf_pkg::PH_MARK || ph == rpcdf_pkg::PH_PAYMARK)
        begin
            w = {sh[23:0], stream_byte};
            biw_next = biw + 2'd1;
            shift_next = w;
            if (biw == 2'd3)
            begin
                final_next = w[31];
                frag_next  = w[30:0];
                shift_next = '0;
                if (ph == rpcdf_pkg::PH_MARK)
                    phase_next = rpcdf_pkg::PH_XID;
                else if (w[30:0] != '0)
                    phase_next = rpcdf_pkg::PH_PAYLOAD;
                else if (w[31])
                begin
                    res.last = 1'b1;
                    phase_next = rpcdf_pkg::PH_MARK;
                end
            end
        end
        else if (ph == rpcdf_pkg::PH_PAYLOAD)
        begin
            frag_next = fr - 31'd1;
            res.kind = rpcdf_pkg::KIND_PAYLOAD;
            res.data = stream_byte;
            if (fr == 31'd1)
            begin
                if (fin)
                begin
                    res.last = 1'b1;
                    phase_next = rpcdf_pkg::PH_MARK;
                end
                else
                    phase_next = rpcdf_pkg::PH_PAYMARK;
            end
        end
        else if (fr == '0)
        begin
            err_next = 1'b1;
            shift_next = {29'd0, rpcdf_pkg::ERR_OVERRUN};
            res.kind = rpcdf_pkg::KIND_ERROR;
            res.err = rpcdf_pkg::ERR_OVERRUN;
        end
        else
        begin
            frag_next = fr - 31'd1;
            if (ph == rpcdf_pkg::PH_CREDBODY || ph == rpcdf_pkg::PH_VERFBODY)
            begin
                is_data = (opq_reg != '0);
                if (is_data)
                    opq_next = opq_reg - 10'd1;
                else
                    pad_next = pad_reg - 2'd1;
                if (opq_next == '0 && pad_next == '0)
                begin
                    if (ph == rpcdf_pkg::PH_CREDBODY)
                        phase_next = rpcdf_pkg::PH_VERFFL;
                    else
                        vend = 1'b1;
                end
                if (!vend && is_data)
                begin
                    res.kind = (ph == rpcdf_pkg::PH_CREDBODY) ? rpcdf_pkg::KIND_CRED
                                                              : rpcdf_pkg::KIND_VERF;
                    res.data = stream_byte;
                end
            end
            else
            begin
                w = {sh[23:0], stream_byte};
                biw_next = biw + 2'd1;
                shift_next = w;
                if (biw == 2'd3)
                begin
                    shift_next = '0;
                    unique case (ph)
                        rpcdf_pkg::PH_XID:
                        begin
                            xid_next = w;
                            phase_next = rpcdf_pkg::PH_MTYPE;
                        end
                        rpcdf_pkg::PH_MTYPE:
                        begin
                            if (w != '0)
                            begin
                                err_next = 1'b1;
                                shift_next = {29'd0, rpcdf_pkg::ERR_NOT_CALL};
                                res.kind = rpcdf_pkg::KIND_ERROR;
                                res.err = rpcdf_pkg::ERR_NOT_CALL;
                            end
                            else
                                phase_next = rpcdf_pkg::PH_RPCVERS;
                        end
                        rpcdf_pkg::PH_RPCVERS:
                        begin
                            if (w != rpcdf_pkg::RPC_VERSION)
                            begin
                                err_next = 1'b1;
                                shift_next = {29'd0, rpcdf_pkg::ERR_RPC_VERS};
                                res.kind = rpcdf_pkg::KIND_ERROR;
                                res.err = rpcdf_pkg::ERR_RPC_VERS;
                            end
                            else
                                phase_next = rpcdf_pkg::PH_PROG;
                        end
                        rpcdf_pkg::PH_PROG:
                        begin
                            prog_next = w;
                            phase_next = rpcdf_pkg::PH_VERS;
                        end
                        rpcdf_pkg::PH_VERS:
                        begin
                            vers_next = w;
                            phase_next = rpcdf_pkg::PH_PROC;
                        end
                        rpcdf_pkg::PH_PROC:
                        begin
                            proc_next = w;
                            phase_next = rpcdf_pkg::PH_CREDFL;
                        end
                        rpcdf_pkg::PH_CREDFL:
                        begin
                            cfl_next = w;
                            phase_next = rpcdf_pkg::PH_CREDLEN;
                        end
                        rpcdf_pkg::PH_VERFFL:
                        begin
                            vfl_next = w;
                            phase_next = rpcdf_pkg::PH_VERFLEN;
                        end
                        default:
                        begin
                            // credential or verifier length
                            if (w > {22'd0, max_opq_reg})
                            begin
                                err_next = 1'b1;
                                shift_next = {29'd0, rpcdf_pkg::ERR_OPAQUE};
                                res.kind = rpcdf_pkg::KIND_ERROR;
                                res.err = rpcdf_pkg::ERR_OPAQUE;
                            end
                            else
                            begin
                                opq_next = w[9:0];
                                pad_next = 2'd0 - w[1:0];
                                if (w[9:0] != '0)
                                    phase_next = (ph == rpcdf_pkg::PH_CREDLEN)
                                        ? rpcdf_pkg::PH_CREDBODY : rpcdf_pkg::PH_VERFBODY;
                                else if (ph == rpcdf_pkg::PH_CREDLEN)
                                    phase_next = rpcdf_pkg::PH_VERFFL;
                                else
                                    vend = 1'b1;
                            end
                        end
                    endcase
                end
            end

            if (vend)
            begin
                res.kind = rpcdf_pkg::KIND_HEADER;
                res.data = is_data ? stream_byte : 8'd0;
                res.last = fin && (frag_next == '0);
                res.xid = xid_next;
                res.prog = prog_next;
                res.vers = vers_next;
                res.proc_num = proc_next;
                res.cred_fl = cfl_next;
                res.verf_fl = vfl_next;
                biw_next = '0;
                shift_next = '0;
                if (fin && frag_next == '0)
                    phase_next = rpcdf_pkg::PH_MARK;
                else if (frag_next == '0)
                    phase_next = rpcdf_pkg::PH_PAYMARK;
                else
                    phase_next = rpcdf_pkg::PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rpcdf_pkg::PH_MARK;
            biw_reg   <= '0;
            shift_reg <= '0;
            frag_reg  <= '0;
            final_reg <= 1'b0;
            opq_reg   <= '0;
            pad_reg   <= '0;
            xid_reg   <= '0;
            prog_reg  <= '0;
            vers_reg  <= '0;
            proc_reg  <= '0;
            cfl_reg   <= '0;
            vfl_reg   <= '0;
            err_reg   <= 1'b0;
            max_opq_reg <= rpcdf_pkg::MAX_OPAQUE_RESET;
        end
        else
        begin
            if (max_opaque_wr)
                max_opq_reg <= max_opaque_data;
            if (accept)
            begin
                phase_reg <= phase_next;
                biw_reg   <= biw_next;
                shift_reg <= shift_next;
                frag_reg  <= frag_next;
                final_reg <= final_next;
                opq_reg   <= opq_next;
                pad_reg   <= pad_next;
                xid_reg   <= xid_next;
                prog_reg  <= prog_next;
                vers_reg  <= vers_next;
                proc_reg  <= proc_next;
                cfl_reg   <= cfl_next;
                vfl_reg   <= vfl_next;
                err_reg   <= err_next;
            end
        end
    end

    rpcdf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign result_kind  = out_res.kind;
    assign data_byte    = out_res.data;
    assign last_payload = out_res.last;
    assign call_xid     = out_res.xid;
    assign program_res  = out_res.prog;
    assign prog_version = out_res.vers;
    assign procedure    = out_res.proc_num;
    assign cred_flavor  = out_res.cred_fl;
    assign verf_flavor  = out_res.verf_fl;
    assign error_code   = out_res.err;

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result_kind == rpcdf_pkg::KIND_ERROR) == (error_code != '0)))
        else $error("error code without error kind");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && err_reg && !restart |=> err_reg)
        else $error("error latch dropped without restart");
    a_err_shift: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> shift_reg[2:0] != '0)
        else $error("latched error without code");

endmodule

[verif/tb_rpc_call_header_deframer.sv]
// Testbench for the RPC call-header deframer: directed and random record streams checked against a predictor
`timescale 1ns / 1ps

module tb_rpc_call_header_deframer;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        max_opaque_wr = 1'b0;
    logic [9:0]  max_opaque_data = 10'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  stream_byte = 8'd0;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  result_kind;
    logic [7:0]  data_byte;
    logic        last_payload;
    logic [31:0] call_xid;
    logic [31:0] program_res;
    logic [31:0] prog_version;
    logic [31:0] procedure;
    logic [31:0] cred_flavor;
    logic [31:0] verf_flavor;
    logic [2:0]  error_code;

    rpc_call_header_deframer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_opaque_wr  (max_opaque_wr),
        .max_opaque_data(max_opaque_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .data_byte      (data_byte),
        .last_payload   (last_payload),
        .call_xid       (call_xid),
        .program_res    (program_res),
        .prog_version   (prog_version),
        .procedure      (procedure),
        .cred_flavor    (cred_flavor),
        .verf_flavor    (verf_flavor),
        .error_code     (error_code)
    );

    // parser mirror
    rpcdf_pkg::phase_t phase;
    logic [1:0]  byte_pos;
    logic [31:0] shift_word;
    logic [30:0] frag_left;
    logic        frag_final;
    logic [9:0]  body_left;
    logic [1:0]  pad_left;
    logic [31:0] hdr_xid, hdr_prog, hdr_vers, hdr_proc, hdr_cred, hdr_verf;
    logic        err_held;
    logic [9:0]  opaque_limit;

    rpcdf_pkg::result_t results_due[$];
    logic [7:0]  rec_bytes[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          records_sent = 0;
    int          headers_seen = 0;
    int          payload_seen = 0;
    int          errors_seen = 0;
    bit          no_idle = 1'b0;
    int          hold_left = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic clear_parser();
        phase = rpcdf_pkg::PH_MARK;
        byte_pos = 2'd0;
        shift_word = 32'd0;
        frag_left = 31'd0;
        frag_final = 1'b0;
        body_left = 10'd0;
        pad_left = 2'd0;
        err_held = 1'b0;
    endtask

    function automatic void flag_error(inout rpcdf_pkg::result_t r, input logic [2:0] code);
        err_held = 1'b1;
        shift_word = {29'd0, code};
        r.kind = rpcdf_pkg::KIND_ERROR;
        r.err = code;
    endfunction

    task automatic emit_header(inout rpcdf_pkg::result_t r, input logic [7:0] b);
        logic ends;
        ends = frag_final && (frag_left == 31'd0);
        r.kind = rpcdf_pkg::KIND_HEADER;
        r.data = b;
        r.last = ends;
        r.xid = hdr_xid;
        r.prog = hdr_prog;
        r.vers = hdr_vers;
        r.proc_num = hdr_proc;
        r.cred_fl = hdr_cred;
        r.verf_fl = hdr_verf;
        byte_pos = 2'd0;
        shift_word = 32'd0;
        if (ends)
            phase = rpcdf_pkg::PH_MARK;
        else if (frag_left == 31'd0)
            phase = rpcdf_pkg::PH_PAYMARK;
        else
            phase = rpcdf_pkg::PH_PAYLOAD;
    endtask

    function automatic bit take_length(inout rpcdf_pkg::result_t r, input logic [31:0] len);
        if (len > {22'd0, opaque_limit})
        begin
            flag_error(r, rpcdf_pkg::ERR_OPAQUE);
            return 1'b0;
        end
        body_left = len[9:0];
        pad_left = 2'd0 - len[1:0];
        return 1'b1;
    endfunction

    task automatic finish_word(inout rpcdf_pkg::result_t r);
        logic [31:0] w;
        w = shift_word;
        case (phase)
            rpcdf_pkg::PH_XID:
            begin
                hdr_xid = w;
                phase = rpcdf_pkg::PH_MTYPE;
            end
            rpcdf_pkg::PH_MTYPE:
            begin
                if (w != 32'd0)
                begin
                    flag_error(r, rpcdf_pkg::ERR_NOT_CALL);
                    return;
                end
                phase = rpcdf_pkg::PH_RPCVERS;
            end
            rpcdf_pkg::PH_RPCVERS:
            begin
                if (w != rpcdf_pkg::RPC_VERSION)
                begin
                    flag_error(r, rpcdf_pkg::ERR_RPC_VERS);
                    return;
                end
                phase = rpcdf_pkg::PH_PROG;
            end
            rpcdf_pkg::PH_PROG:
            begin
                hdr_prog = w;
                phase = rpcdf_pkg::PH_VERS;
            end
            rpcdf_pkg::PH_VERS:
            begin
                hdr_vers = w;
                phase = rpcdf_pkg::PH_PROC;
            end
            rpcdf_pkg::PH_PROC:
            begin
                hdr_proc = w;
                phase = rpcdf_pkg::PH_CREDFL;
            end
            rpcdf_pkg::PH_CREDFL:
            begin
                hdr_cred = w;
                phase = rpcdf_pkg::PH_CREDLEN;
            end
            rpcdf_pkg::PH_CREDLEN:
            begin
                if (!take_length(r, w))
                    return;
                phase = (body_left == 0 && pad_left == 0) ? rpcdf_pkg::PH_VERFFL
                                                          : rpcdf_pkg::PH_CREDBODY;
            end
            rpcdf_pkg::PH_VERFFL:
            begin
                hdr_verf = w;
                phase = rpcdf_pkg::PH_VERFLEN;
            end
            default:
            begin
                if (!take_length(r, w))
                    return;
                if (body_left == 0 && pad_left == 0)
                    emit_header(r, 8'd0);
                else
                    phase = rpcdf_pkg::PH_VERFBODY;
            end
        endcase
        shift_word = 32'd0;
    endtask

    task automatic predict_result(input logic [7:0] b, input logic rs,
                                  output rpcdf_pkg::result_t r);
        bit is_cred;
        bit has_data;
        r = '0;
        if (rs)
            clear_parser();
        if (err_held)
        begin
            r.kind = rpcdf_pkg::KIND_ERROR;
            r.err = shift_word[2:0];
            return;
        end
        if (phase == rpcdf_pkg::PH_MARK || phase == rpcdf_pkg::PH_PAYMARK)
        begin
            shift_word = {shift_word[23:0], b};
            byte_pos = byte_pos + 2'd1;
            if (byte_pos == 2'd0)
            begin
                frag_final = shift_word[31];
                frag_left = shift_word[30:0];
                shift_word = 32'd0;
                if (phase == rpcdf_pkg::PH_MARK)
                    phase = rpcdf_pkg::PH_XID;
                else if (frag_left != 31'd0)
                    phase = rpcdf_pkg::PH_PAYLOAD;
                else if (frag_final)
                begin
                    r.last = 1'b1;
                    phase = rpcdf_pkg::PH_MARK;
                end
            end
            return;
        end
        if (phase == rpcdf_pkg::PH_PAYLOAD)
        begin
            frag_left = frag_left - 31'd1;
            r.kind = rpcdf_pkg::KIND_PAYLOAD;
            r.data = b;
            if (frag_left == 31'd0)
            begin
                if (frag_final)
                begin
                    r.last = 1'b1;
                    phase = rpcdf_pkg::PH_MARK;
                end
                else
                    phase = rpcdf_pkg::PH_PAYMARK;
            end
            return;
        end
        if (frag_left == 31'd0)
        begin
            flag_error(r, rpcdf_pkg::ERR_OVERRUN);
            return;
        end
        frag_left = frag_left - 31'd1;
        if (phase == rpcdf_pkg::PH_CREDBODY || phase == rpcdf_pkg::PH_VERFBODY)
        begin
            is_cred = (phase == rpcdf_pkg::PH_CREDBODY);
            has_data = (body_left != 0);
            if (has_data)
                body_left = body_left - 10'd1;
            else
                pad_left = pad_left - 2'd1;
            if (body_left == 0 && pad_left == 0)
            begin
                if (is_cred)
                    phase = rpcdf_pkg::PH_VERFFL;
                else
                begin
                    emit_header(r, has_data ? b : 8'd0);
                    return;
                end
            end
            if (has_data)
            begin
                r.kind = is_cred ? rpcdf_pkg::KIND_CRED : rpcdf_pkg::KIND_VERF;
                r.data = b;
            end
            return;
        end
        shift_word = {shift_word[23:0], b};
        byte_pos = byte_pos + 2'd1;
        if (byte_pos == 2'd0)
            finish_word(r);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    task automatic send_word(input logic [7:0] b, input logic rs);
        rpcdf_pkg::result_t r;
        if (!no_idle && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= b;
        restart <= rs;
        do
            @(posedge clk);
        while (in_stall);
        predict_result(b, rs, r);
        results_due = {results_due, r};
        words_sent++;
    endtask

    task automatic hold_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        hold_input();
        guard = 0;
        while (results_due.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [9:0] v);
        drain();
        max_opaque_wr <= 1'b1;
        max_opaque_data <= v;
        @(posedge clk);
        max_opaque_wr <= 1'b0;
        opaque_limit = v;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            rec_bytes = {rec_bytes, w[8*i +: 8]};
    endtask

    task automatic push_random_bytes(input int n);
        repeat (n) rec_bytes = {rec_bytes, 8'($urandom)};
    endtask

    function automatic logic [31:0] pick_length();
        int top;
        top = (opaque_limit < 10'd12) ? opaque_limit : 12;
        if ($urandom_range(9) == 0)
            return $urandom_range(0, opaque_limit);
        return $urandom_range(0, top);
    endfunction

    // fault: 0 clean, 1 message type, 2 rpc version, 3 cred length, 4 verf length, 5 overrun
    task automatic send_call(input int fault, input int max_pay);
        logic [31:0] clen, vlen;
        int hlen, plen, p1, rest, chunk;
        logic fin, rs;
        rec_bytes.delete();
        clen = pick_length();
        vlen = pick_length();
        if (fault == 3)
            clen = $urandom_range(1) ? ($urandom | 32'h400) : opaque_limit + 32'd1;
        if (fault == 4)
            vlen = $urandom_range(1) ? ($urandom | 32'h400) : opaque_limit + 32'd1;
        hlen = 40;
        if (fault != 3)
            hlen += clen + ((4 - clen % 4) % 4);
        if (fault != 3 && fault != 4)
            hlen += vlen + ((4 - vlen % 4) % 4);
        plen = $urandom_range(0, max_pay);
        p1 = $urandom_range(0, plen);
        rest = plen - p1;
        fin = (rest == 0) && ($urandom_range(3) != 0);
        if (fault == 5)
            push_word({1'b1, 31'($urandom_range(0, hlen - 1))});
        else
            push_word({fin, 31'(hlen + p1)});
        push_word($urandom);
        push_word(fault == 1 ? ($urandom | 32'd1) : 32'd0);
        push_word(fault == 2 ? ($urandom_range(1) ? 32'd0 : $urandom | 32'd4)
                             : rpcdf_pkg::RPC_VERSION);
        repeat (4) push_word($urandom);
        push_word(clen);
        if (fault != 3)
        begin
            push_random_bytes(int'(clen + (4 - clen % 4) % 4));
            push_word($urandom);
            push_word(vlen);
            if (fault != 4)
                push_random_bytes(int'(vlen + (4 - vlen % 4) % 4));
        end
        if (fault == 0)
        begin
            push_random_bytes(p1);
            if (!fin && rest == 0)
            begin
                if ($urandom_range(1))
                    push_word(32'd0);
                push_word(32'h8000_0000);
            end
            while (rest > 0)
            begin
                chunk = $urandom_range(0, rest);
                push_word({chunk == rest, 31'(chunk)});
                push_random_bytes(chunk);
                rest -= chunk;
            end
        end
        else
            push_random_bytes($urandom_range(0, 6));
        rs = err_held || phase != rpcdf_pkg::PH_MARK || byte_pos != 0 || $urandom_range(9) == 0;
        foreach (rec_bytes[i])
            send_word(rec_bytes[i], (i == 0) ? rs : 1'b0);
        records_sent++;
    endtask

    task automatic send_mix(input int n_words);
        int stop;
        stop = words_sent + n_words;
        while (words_sent < stop)
        begin
            case ($urandom_range(19))
                0: send_call(1, 8);
                1: send_call(2, 8);
                2: send_call(3, 8);
                3: send_call(4, 8);
                4: send_call(5, 8);
                5: repeat ($urandom_range(1, 8)) send_word(8'($urandom), $urandom_range(15) == 0);
                default: send_call(0, 24);
            endcase
        end
    endtask

    task automatic test_directed();
        send_word(8'h80, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h03, 1'b0);
        repeat (4) send_word(8'hff, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b1);
        repeat (3) send_word(8'hff, 1'b0);
        repeat (4) send_word(8'h00, 1'b0);
        repeat (4) send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h7f, 1'b1);
    endtask

    task automatic test_clean_calls();
        no_idle = 1'b1;
        send_call(0, 16);
        no_idle = 1'b0;
        send_call(0, 24);
    endtask

    task automatic test_faults();
        for (int f = 1; f <= 5; f++)
            send_call(f, 8);
    endtask

    task automatic test_limits();
        set_limit(10'd0);
        send_mix(20);
        set_limit(10'd1023);
        send_call(0, 4);
        send_call(3, 4);
        send_mix(20);
        set_limit(10'($urandom_range(1, 1022)));
        send_mix(20);
        set_limit(rpcdf_pkg::MAX_OPAQUE_RESET);
    endtask

    task automatic test_backpressure();
        hold_left = 300;
        send_mix(60);
    endtask

    task automatic test_random_mix();
        send_mix(80);
    endtask

    always @(posedge clk)
    begin
        rpcdf_pkg::result_t want;
        if (out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
                report("unexpected result", {29'd0, result_kind}, 32'd0);
            else
            begin
                want = results_due.pop_front();
                if (result_kind != want.kind)
                    report("kind", 32'(result_kind), 32'(want.kind));
                if (data_byte != want.data)
                    report("data_byte", 32'(data_byte), 32'(want.data));
                if (last_payload != want.last)
                    report("last_payload", 32'(last_payload), 32'(want.last));
                if (call_xid != want.xid) report("call_xid", call_xid, want.xid);
                if (program_res != want.prog) report("program", program_res, want.prog);
                if (prog_version != want.vers) report("version", prog_version, want.vers);
                if (procedure != want.proc_num) report("procedure", procedure, want.proc_num);
                if (cred_flavor != want.cred_fl) report("cred_flavor", cred_flavor, want.cred_fl);
                if (verf_flavor != want.verf_fl) report("verf_flavor", verf_flavor, want.verf_fl);
                if (error_code != want.err)
                    report("error_code", 32'(error_code), 32'(want.err));
                if (want.kind == rpcdf_pkg::KIND_HEADER) headers_seen++;
                if (want.kind == rpcdf_pkg::KIND_PAYLOAD) payload_seen++;
                if (want.kind == rpcdf_pkg::KIND_ERROR) errors_seen++;
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 30);
    end

    initial
    begin
        clear_parser();
        opaque_limit = rpcdf_pkg::MAX_OPAQUE_RESET;
        {hdr_xid, hdr_prog, hdr_vers, hdr_proc, hdr_cred, hdr_verf} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_clean_calls();
        test_faults();
        test_backpressure();
        test_limits();
        test_random_mix();
        drain();
        $display("sent %0d words in %0d records, opaque limits 0, 1023, random and reset",
                 words_sent, records_sent);
        $display("checked %0d headers, %0d payload words, %0d error words",
                 headers_seen, payload_seen, errors_seen);
        if (mismatches == 0 && results_due.size() == 0)
            $display("tb_rpc_call_header_deframer: PASS");
        else
            $display("tb_rpc_call_header_deframer: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_rpc_call_header_deframer: FAIL");
        $finish;
    end

endmodule

[files.f]
hw/rtl/rpcdf_pkg.sv
hw/rtl/rpcdf_out_reg.sv
hw/rtl/rpc_call_header_deframer.sv
verif/tb_rpc_call_header_deframer.sv
